/* hw/rtl/msps_pkg.sv */
// Shared types, command codes and width helpers for the servo pulse sequencer.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package msps_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int FRAME_US_DEF     = 20000;
  localparam int DEFAULT_US_DEF   = 1500;
  localparam int MIN_US_DEF       = 1000;
  localparam int MAX_US_DEF       = 2000;

  localparam logic [3:0] TOTAL_MAX = 4'd15;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_ATTACH = 2'd2,
    CMD_DETACH = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  servo_slot;
    logic [15:0] pulse_width;
    logic [2:0]  pin_select;
  } in_word_t;

  typedef struct packed {
    logic [7:0] port_level;
    logic [7:0] port_drive;
    logic       status;
  } out_word_t;

  typedef struct packed {
    logic [7:0] coarse;
    logic [7:0] fine;
  } width_split_t;

  function automatic width_split_t split_width(input logic [15:0] w, input int min_us,
                                               input int max_us);
    logic [15:0]  c;
    width_split_t r;
    c = w;
    if (c < 16'(min_us)) c = 16'(min_us);
    if (c > 16'(max_us)) c = 16'(max_us);
    r.coarse = c[14:7];
    r.fine   = 8'd255 - {c[6:0], 1'b0};
    return r;
  endfunction

  function automatic logic [7:0] gap_coarse(input logic [3:0] tot, input int frame_us,
                                            input int default_us);
    int diff;
    diff = frame_us - (int'(tot) + 1) * default_us;
    if (diff < 0) return 8'd0;
    return 8'(diff >>> 7);
  endfunction

endpackage

/* hw/rtl/multiplexed_servo_pulse_sequencer_top.sv */
// Multiplexed servo pulse sequencer: input register, one pass of update logic, result register.
// Depends on msps_pkg for word types, command codes and width helpers.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall / in_word) carries one command word: a timer
//   tick, a pulse width write, an attach or a detach for channels 1..NUM_CHANNELS.
//   Result channel (out_valid / out_stall / out_word) returns one word per command:
//   the pin levels, the pin output enables and a status bit (1 = channel out of range).
//   Path: an accepted word passes through the input register and then the result
//   register; a stall on the result side holds it back.
//   Throughput: one word per clock while out_stall is low; the input register and the
//   result register each hold one word, and the slot state updates as a word moves
//   from the input register into the result register.
//   Stall: while out_stall holds a pending result, the input register fills and
//   in_stall rises; nothing is dropped.
//   Reset (rst_n low, synchronous): all counters, slot tables, pin levels and enables
//   clear; both registers empty. The block is ready the cycle after reset releases.
module multiplexed_servo_pulse_sequencer_top
  import msps_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int FRAME_US     = FRAME_US_DEF,
  parameter int DEFAULT_US   = DEFAULT_US_DEF,
  parameter int MIN_US       = MIN_US_DEF,
  parameter int MAX_US       = MAX_US_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int NUM_SLOTS = NUM_CHANNELS + 1;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;

  logic [7:0]        tick_r, tick_nxt;
  logic [7:0]        ovf_r, ovf_nxt;
  logic [SLOT_W-1:0] active_r, active_nxt;
  logic [7:0]        cur_coarse_r, cur_coarse_nxt;
  logic [7:0]        cur_fine_r, cur_fine_nxt;
  logic [2:0]        cur_pin_r, cur_pin_nxt;
  logic              cur_en_r, cur_en_nxt;
  logic [7:0]        gap_r, gap_nxt;
  logic [3:0]        total_r, total_nxt;
  logic [7:0]        level_r, level_nxt;
  logic [7:0]        drive_r, drive_nxt;

  logic [7:0]           coarse_r [NUM_SLOTS];
  logic [7:0]           fine_r   [NUM_SLOTS];
  logic [2:0]           pin_r    [NUM_SLOTS];
  logic [2:0]           pin_dt_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] en_r;

  logic              adv;
  logic              status;
  logic              slot_ok;
  logic [SLOT_W-1:0] ch;
  logic [SLOT_W-1:0] slot_next;
  logic [7:0]        act_coarse;
  logic [7:0]        tick_inc;
  logic [7:0]        ovf_inc;
  logic              we_width;
  logic              we_attach;
  logic              we_detach;
  width_split_t      split_w;
  width_split_t      split_def;

  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign ch         = s1_word_r.servo_slot[SLOT_W-1:0];
  assign slot_ok    = (s1_word_r.servo_slot != 4'd0) &&
                      (s1_word_r.servo_slot <= 4'(NUM_CHANNELS));
  assign slot_next  = (active_r == SLOT_W'(NUM_CHANNELS)) ? '0 : active_r + 1'b1;
  assign act_coarse = (active_r == '0) ? gap_r : cur_coarse_r;
  assign tick_inc   = tick_r + 8'd1;
  assign ovf_inc    = ovf_r + 8'd1;
  assign split_w    = split_width(s1_word_r.pulse_width, MIN_US, MAX_US);
  assign split_def  = split_width(16'(DEFAULT_US), MIN_US, MAX_US);

  always_comb begin
    tick_nxt       = tick_r;
    ovf_nxt        = ovf_r;
    active_nxt     = active_r;
    cur_coarse_nxt = cur_coarse_r;
    cur_fine_nxt   = cur_fine_r;
    cur_pin_nxt    = cur_pin_r;
    cur_en_nxt     = cur_en_r;
    gap_nxt        = gap_r;
    total_nxt      = total_r;
    level_nxt      = level_r;
    drive_nxt      = drive_r;
    status         = 1'b0;
    we_width       = 1'b0;
    we_attach      = 1'b0;
    we_detach      = 1'b0;
    if (adv) begin
      if (s1_word_r.cmd == CMD_TICK) begin
        tick_nxt = tick_inc;
        if (tick_inc == 8'd0) begin
          ovf_nxt = ovf_inc;
          if (ovf_inc == act_coarse) begin
            tick_nxt = cur_fine_r;
          end else if (ovf_inc > act_coarse) begin
            if (cur_en_r) begin
              level_nxt[cur_pin_r] = 1'b0;
            end
            active_nxt = slot_next;
            ovf_nxt    = 8'd0;
            tick_nxt   = 8'd0;
            if (slot_next != '0) begin
              cur_coarse_nxt = coarse_r[slot_next];
              cur_fine_nxt   = fine_r[slot_next];
              cur_pin_nxt    = pin_r[slot_next];
              cur_en_nxt     = en_r[slot_next];
              if (en_r[slot_next]) begin
                level_nxt[pin_r[slot_next]] = 1'b1;
              end
            end else begin
              cur_coarse_nxt = 8'd0;
              cur_fine_nxt   = 8'd0;
              cur_pin_nxt    = 3'd0;
              cur_en_nxt     = 1'b0;
            end
          end
        end
      end else if (!slot_ok) begin
        status = 1'b1;
      end else begin
        unique case (s1_word_r.cmd)
          CMD_WRITE: begin
            we_width = 1'b1;
            if (ch == active_r) begin
              cur_coarse_nxt = split_w.coarse;
              cur_fine_nxt   = split_w.fine;
            end
          end
          CMD_ATTACH: begin
            we_attach = 1'b1;
            total_nxt = (total_r == TOTAL_MAX) ? total_r : total_r + 4'd1;
            gap_nxt   = gap_coarse(total_nxt, FRAME_US, DEFAULT_US);
            drive_nxt[s1_word_r.pin_select] = 1'b1;
            level_nxt[s1_word_r.pin_select] = 1'b0;
            if (ch == active_r) begin
              cur_coarse_nxt = split_def.coarse;
              cur_fine_nxt   = split_def.fine;
              cur_pin_nxt    = s1_word_r.pin_select;
              cur_en_nxt     = 1'b1;
            end
          end
          CMD_DETACH: begin
            we_detach = 1'b1;
            total_nxt = (total_r == 4'd0) ? total_r : total_r - 4'd1;
            gap_nxt   = gap_coarse(total_nxt, FRAME_US, DEFAULT_US);
            drive_nxt[pin_dt_r[ch]] = 1'b0;
            if (ch == active_r) begin
              cur_en_nxt = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      tick_r       <= 8'd0;
      ovf_r        <= 8'd0;
      active_r     <= '0;
      cur_coarse_r <= 8'd0;
      cur_fine_r   <= 8'd0;
      cur_pin_r    <= 3'd0;
      cur_en_r     <= 1'b0;
      gap_r        <= 8'd0;
      total_r      <= 4'd0;
      level_r      <= 8'd0;
      drive_r      <= 8'd0;
      en_r         <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        coarse_r[i] <= 8'd0;
        fine_r[i]   <= 8'd0;
        pin_r[i]    <= 3'd0;
        pin_dt_r[i] <= 3'd0;
      end
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      tick_r       <= tick_nxt;
      ovf_r        <= ovf_nxt;
      active_r     <= active_nxt;
      cur_coarse_r <= cur_coarse_nxt;
      cur_fine_r   <= cur_fine_nxt;
      cur_pin_r    <= cur_pin_nxt;
      cur_en_r     <= cur_en_nxt;
      gap_r        <= gap_nxt;
      total_r      <= total_nxt;
      level_r      <= level_nxt;
      drive_r      <= drive_nxt;
      if (we_width) begin
        coarse_r[ch] <= split_w.coarse;
        fine_r[ch]   <= split_w.fine;
      end
      if (we_attach) begin
        coarse_r[ch] <= split_def.coarse;
        fine_r[ch]   <= split_def.fine;
        pin_r[ch]    <= s1_word_r.pin_select;
        pin_dt_r[ch] <= s1_word_r.pin_select;
        en_r[ch]     <= 1'b1;
      end
      if (we_detach) begin
        en_r[ch] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_word_r <= in_word;
    end
    if (adv) begin
      out_word_r.port_level <= level_nxt;
      out_word_r.port_drive <= drive_nxt;
      out_word_r.status     <= status;
    end
  end

endmodule

/* hw/rtl/msps_checker.sv */
// Port-level checker for the servo pulse sequencer, bound to the top level.
// Depends on msps_pkg for the word types.
`timescale 1ns / 1ps

module msps_checker
  import msps_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side is free");

  a_in_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_word)))
    else $error("stalled input word changed or dropped");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result word changed or dropped");

  a_flow : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> ##1 out_valid)
    else $error("accepted word did not reach the result register");

endmodule

bind multiplexed_servo_pulse_sequencer_top msps_checker u_msps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
